/* rtl/tksel_pkg.sv */
// Shared types and constants for the top-K class selector.
`timescale 1ns / 1ps

package tksel_pkg;

  localparam int TOP_K_DEF       = 5;
  localparam int MAX_CLASSES_DEF = 4096;

  localparam int SAMPLE_W    = 8;
  localparam int VALUE_W     = 9;
  localparam int CLASS_W     = 12;
  localparam int SCALE_W     = 24;
  localparam int SCORE_W     = 33;
  localparam int CFG_INDEX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_IS_UNSIGNED = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCORE_SCALE        = 1'd1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
    logic [CLASS_W-1:0]        cls;
  } slot_t;

  localparam slot_t SLOT_EMPTY = '{valid: 1'b0, value: '0, cls: '0};

endpackage

/* rtl/top_k_class_selector.sv */
// Top level of the top-K class selector: cell chain, drain queue and scaling output.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// sample    in         sample_valid/sample_ready  sample, end_of_scores
// result    out        result_valid/result_ready  class_index, score, last_of_run
// cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One score is taken per cycle while sample_ready is high; the TOP_K cells
// compare it in parallel and shift the ranked list by one place in the same cycle.
// The end-marked transaction copies the updated list into a drain queue and
// clears the cells, so the next vector starts on the following cycle.
// Results leave one per cycle while result_ready allows, through a 9x24
// multiplier into the output register, each after passing the drain queue.
// An end-marked sample waits while the drain queue still holds results.
// Reset is synchronous; cfg_ready is always high.

module top_k_class_selector #(
  parameter int TOP_K       = tksel_pkg::TOP_K_DEF,
  parameter int MAX_CLASSES = tksel_pkg::MAX_CLASSES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   sample_valid,
  output logic                                   sample_ready,
  input  logic [tksel_pkg::SAMPLE_W-1:0]         sample,
  input  logic                                   end_of_scores,
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output logic [tksel_pkg::CLASS_W-1:0]          class_index,
  output logic signed [tksel_pkg::SCORE_W-1:0]   score,
  output logic                                   last_of_run,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tksel_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [tksel_pkg::SCALE_W-1:0]          cfg_data
);
  import tksel_pkg::*;

  localparam int CNT_W = $clog2(MAX_CLASSES + 1);

  // Configuration registers
  logic               sample_is_unsigned;
  logic [SCALE_W-1:0] score_scale;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_is_unsigned <= 1'b0;
      score_scale        <= SCALE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SAMPLE_IS_UNSIGNED: sample_is_unsigned <= cfg_data[0];
        REG_SCORE_SCALE:        score_scale        <= cfg_data;
        default:                ;
      endcase
    end
  end

  // Input side
  logic                      accept;
  logic                      ins_en;
  logic                      clr;
  logic [CNT_W-1:0]          counter;
  logic [CNT_W+CLASS_W-1:0]  counter_wide;
  logic [CLASS_W-1:0]        cur_cls;
  logic signed [VALUE_W-1:0] cur_value;
  logic                      scale_nz;

  slot_t            cell_q   [TOP_K];
  slot_t            cell_ins [TOP_K];
  logic [TOP_K-1:0] take;

  slot_t            dq [TOP_K];
  logic [TOP_K:0]   dvalid;
  logic             pop;

  assign sample_ready = !end_of_scores || !dq[0].valid;
  assign accept       = sample_valid && sample_ready;
  assign ins_en       = accept && (counter < CNT_W'(MAX_CLASSES));
  assign clr          = accept && end_of_scores;
  assign scale_nz     = (score_scale != '0);

  // Low 12 bits of the class position, whatever the counter width
  assign counter_wide = {{CLASS_W{1'b0}}, counter};
  assign cur_cls      = counter_wide[CLASS_W-1:0];
  assign cur_value    = sample_is_unsigned ? $signed({1'b0, sample})
                                           : $signed({sample[SAMPLE_W-1], sample});

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else if (clr) begin
      counter <= '0;
    end else if (ins_en) begin
      counter <= counter + 1'b1;
    end
  end

  // Ranking chain, best first; a cell below the insert point takes the
  // old entry of the cell above it
  for (genvar i = 0; i < TOP_K; i++) begin : g_cell
    slot_t prev_ins;
    logic  prev_take;
    if (i == 0) begin : g_head
      assign prev_ins  = SLOT_EMPTY;
      assign prev_take = 1'b0;
    end else begin : g_link
      assign prev_ins  = cell_q[i-1];
      assign prev_take = take[i-1];
    end

    tksel_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .value     (cur_value),
      .cls       (cur_cls),
      .scale_nz  (scale_nz),
      .ins_en    (ins_en),
      .clr       (clr),
      .prev_ins  (prev_ins),
      .prev_take (prev_take),
      .q         (cell_q[i]),
      .q_ins     (cell_ins[i]),
      .take      (take[i])
    );
  end

  // Drain queue: loaded with the final list, shifts toward the head on each pop
  always_comb begin
    for (int i = 0; i < TOP_K; i++) begin
      dvalid[i] = dq[i].valid;
    end
    dvalid[TOP_K] = 1'b0;
  end

  assign pop = dq[0].valid && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TOP_K; i++) begin
        dq[i].valid <= 1'b0;
      end
    end else if (clr) begin
      for (int i = 0; i < TOP_K; i++) begin
        dq[i] <= cell_ins[i];
      end
    end else if (pop) begin
      for (int i = 0; i < TOP_K - 1; i++) begin
        dq[i] <= dq[i+1];
      end
      dq[TOP_K-1] <= SLOT_EMPTY;
    end
  end

  // Scale the head entry straight into the output register
  logic signed [SCORE_W-1:0] prod;

  assign prod = SCORE_W'($signed(dq[0].value)) * SCORE_W'($signed({1'b0, score_scale}));

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      class_index <= dq[0].cls;
      score       <= prod;
      last_of_run <= !dvalid[1];
    end
  end

endmodule

/* rtl/tksel_cell.sv */
// One ranking cell: holds a kept score and takes the new score or its neighbor's.
`timescale 1ns / 1ps

module tksel_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [tksel_pkg::VALUE_W-1:0] value,
  input  logic [tksel_pkg::CLASS_W-1:0]      cls,
  input  logic                               scale_nz,
  input  logic                               ins_en,
  input  logic                               clr,
  input  tksel_pkg::slot_t                   prev_ins,
  input  logic                               prev_take,
  output tksel_pkg::slot_t                   q,
  output tksel_pkg::slot_t                   q_ins,
  output logic                               take
);
  import tksel_pkg::*;

  // New score wins over an empty slot, or a strictly smaller one if scale_nz.
  // take is high once the insert point is here or further up the chain;
  // below that point every cell shifts down by one.
  always_comb begin
    take  = prev_take || !q.valid || (scale_nz && (value > q.value));
    q_ins = q;
    if (ins_en) begin
      if (prev_take) begin
        q_ins = prev_ins;
      end else if (take) begin
        q_ins = '{valid: 1'b1, value: value, cls: cls};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (clr) begin
      q <= SLOT_EMPTY;
    end else begin
      q <= q_ins;
    end
  end

endmodule

/* rtl/tksel_checker.sv */
// Port-level checks for the top-K class selector, bound to the top level.
`timescale 1ns / 1ps

module tksel_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 sample_valid,
  input logic                                 sample_ready,
  input logic                                 end_of_scores,
  input logic                                 result_valid,
  input logic                                 result_ready,
  input logic [tksel_pkg::CLASS_W-1:0]        class_index,
  input logic signed [tksel_pkg::SCORE_W-1:0] score,
  input logic                                 last_of_run
);
  import tksel_pkg::*;

  // Stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(class_index) && $stable(score) && $stable(last_of_run))
    else $error("result changed while stalled");

  // A run continues without a gap once a non-final result is taken
  a_run_no_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !last_of_run |=> result_valid)
    else $error("run broke before its last result");

  // Scores within a run never rise
  a_run_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !last_of_run |=> score <= $past(score))
    else $error("run not in descending order");

  // An accepted end mark, with reset held low, is followed by a result
  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready && end_of_scores ##1 !rst) |=> result_valid)
    else $error("no result after end of scores");

endmodule

bind top_k_class_selector tksel_checker u_tksel_checker (.*);
